/* rtl/sfcp_pkg.sv */
`default_nettype none

package sfcp_pkg;

    localparam int unsigned FRAME_BYTES = 64;
    localparam int unsigned POS_W       = 7;

    // byte positions within a frame
    localparam logic [POS_W-1:0] POS_WORD_START = 7'd4;
    localparam logic [POS_W-1:0] POS_AIR_INDEX  = 7'd58;
    localparam logic [POS_W-1:0] POS_VERSION    = 7'd60;
    localparam logic [POS_W-1:0] POS_ERROR      = 7'd61;
    localparam logic [POS_W-1:0] POS_SUM_END    = 7'd62;
    localparam logic [POS_W-1:0] POS_LAST       = 7'd63;
    localparam logic [POS_W-1:0] POS_IDLE       = 7'd64;

    // field codes of the trailing byte fields
    localparam logic [4:0] CODE_AIR_INDEX = 5'd19;
    localparam logic [4:0] CODE_VERSION   = 5'd20;
    localparam logic [4:0] CODE_ERROR     = 5'd21;

    typedef struct packed {
        logic       done;
        logic       ok;
        logic [7:0] index_byte;
        logic [7:0] version_byte;
        logic [7:0] error_byte;
    } t_rx_status;

endpackage

`default_nettype wire

/* rtl/sfcp_word_mem.sv */
`default_nettype none

module sfcp_word_mem #(
    parameter int unsigned DEPTH = 19,
    parameter int unsigned AW    = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [15:0]   i_wr_data,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [15:0]   o_rd_data
);

    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* rtl/sfcp_frame_rx.sv */
`default_nettype none

module sfcp_frame_rx #(
    parameter int unsigned WORD_COUNT = 19,
    parameter int unsigned AW         = 5
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_acc,
    input  wire logic [7:0]           i_rx_byte,
    input  wire logic                 i_frame_start,
    output logic                      o_at_last,
    output logic                      o_wr_en,
    output logic [AW-1:0]             o_wr_addr,
    output logic [15:0]               o_wr_data,
    output sfcp_pkg::t_rx_status      o_status
);

    localparam logic [sfcp_pkg::POS_W-1:0] WORD_END =
        sfcp_pkg::POS_WORD_START + sfcp_pkg::POS_W'(2 * WORD_COUNT);

    logic [sfcp_pkg::POS_W-1:0] r_pos, n_pos;
    logic [15:0]                r_sum, n_sum;
    logic [7:0]                 r_high, r_index, r_version, r_error, r_sum_high;
    logic [sfcp_pkg::POS_W-1:0] pos;
    logic [sfcp_pkg::POS_W-1:0] off;
    logic [15:0]                sum_base;
    logic                       active;
    logic                       in_words;

    assign pos      = i_frame_start ? '0 : r_pos;
    assign sum_base = i_frame_start ? 16'd0 : r_sum;
    assign active   = i_acc && (i_frame_start || (r_pos < sfcp_pkg::POS_IDLE));
    assign off      = pos - sfcp_pkg::POS_WORD_START;
    assign in_words = (pos >= sfcp_pkg::POS_WORD_START) && (pos < WORD_END);

    // the offered byte would close the frame
    assign o_at_last = !i_frame_start && (r_pos == sfcp_pkg::POS_LAST);

    always_comb begin
        n_pos = r_pos;
        n_sum = r_sum;
        if (active) begin
            n_pos = pos + 1'b1;
            n_sum = (pos < sfcp_pkg::POS_SUM_END) ? sum_base + {8'd0, i_rx_byte} : sum_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= sfcp_pkg::POS_IDLE;
            r_sum      <= '0;
            r_high     <= '0;
            r_index    <= '0;
            r_version  <= '0;
            r_error    <= '0;
            r_sum_high <= '0;
        end else begin
            r_pos <= n_pos;
            r_sum <= n_sum;
            if (active) begin
                if (in_words && !off[0]) r_high <= i_rx_byte;
                if (pos == sfcp_pkg::POS_AIR_INDEX) r_index   <= i_rx_byte;
                if (pos == sfcp_pkg::POS_VERSION)   r_version <= i_rx_byte;
                if (pos == sfcp_pkg::POS_ERROR)     r_error   <= i_rx_byte;
                if (pos == sfcp_pkg::POS_SUM_END)   r_sum_high <= i_rx_byte;
            end
        end
    end

    // odd offset in the word area completes a big-endian word
    assign o_wr_en   = active && in_words && off[0];
    assign o_wr_addr = AW'(off[sfcp_pkg::POS_W-1:1]);
    assign o_wr_data = {r_high, i_rx_byte};

    always_comb begin
        o_status.done         = active && (pos == sfcp_pkg::POS_LAST);
        o_status.ok           = ({r_sum_high, i_rx_byte} == r_sum);
        o_status.index_byte   = r_index;
        o_status.version_byte = r_version;
        o_status.error_byte   = r_error;
    end

endmodule

`default_nettype wire

/* rtl/sfcp_emit_seq.sv */
`default_nettype none

module sfcp_emit_seq #(
    parameter int unsigned WORD_COUNT = 19,
    parameter int unsigned AW         = 5
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire sfcp_pkg::t_rx_status i_status,
    input  wire logic [15:0]          i_rd_data,
    output logic      [AW-1:0]        o_rd_addr,
    output logic                      o_busy,
    output logic                      o_slot_free,
    input  wire logic                 i_out_ready,
    output logic                      o_out_valid,
    output logic [4:0]                o_field_index,
    output logic [15:0]               o_field_value,
    output logic                      o_checksum_ok,
    output logic                      o_last
);

    localparam logic [4:0] LAST_WORD = 5'(WORD_COUNT - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_PUSH
    } t_state;

    t_state      r_state;
    logic [4:0]  r_idx;
    logic        r_out_valid;
    logic [4:0]  r_field_index;
    logic [15:0] r_field_value;
    logic        r_checksum_ok;
    logic        r_last;
    logic        slot_free;
    logic        is_word;
    logic [15:0] push_value;
    logic [4:0]  next_idx;

    assign slot_free = !r_out_valid || i_out_ready;
    assign is_word   = (r_idx <= LAST_WORD);
    assign next_idx  = (r_idx == LAST_WORD) ? sfcp_pkg::CODE_AIR_INDEX : r_idx + 5'd1;
    assign o_rd_addr = is_word ? AW'(r_idx) : '0;

    always_comb begin
        case (r_idx)
            sfcp_pkg::CODE_AIR_INDEX: push_value = {8'd0, i_status.index_byte};
            sfcp_pkg::CODE_VERSION:   push_value = {8'd0, i_status.version_byte};
            sfcp_pkg::CODE_ERROR:     push_value = {8'd0, i_status.error_byte};
            default:                  push_value = i_rd_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_out_ready) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_status.done) begin
                        if (i_status.ok) begin
                            r_idx   <= '0;
                            r_state <= S_FETCH;
                        end else begin
                            // checksum failure: one result, slot known free
                            r_out_valid   <= 1'b1;
                            r_field_index <= '0;
                            r_field_value <= '0;
                            r_checksum_ok <= 1'b0;
                            r_last        <= 1'b1;
                        end
                    end
                end
                S_FETCH: begin
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (slot_free) begin
                        r_out_valid   <= 1'b1;
                        r_field_index <= r_idx;
                        r_field_value <= push_value;
                        r_checksum_ok <= 1'b1;
                        r_last        <= (r_idx == sfcp_pkg::CODE_ERROR);
                        r_idx         <= next_idx;
                        if (r_idx == sfcp_pkg::CODE_ERROR) begin
                            r_state <= S_IDLE;
                        end else if (next_idx <= LAST_WORD) begin
                            r_state <= S_FETCH;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_slot_free   = slot_free;
    assign o_out_valid   = r_out_valid;
    assign o_field_index = r_field_index;
    assign o_field_value = r_field_value;
    assign o_checksum_ok = r_checksum_ok;
    assign o_last        = r_last;

endmodule

`default_nettype wire

/* rtl/sensor_frame_checksum_parser_top.sv */
// Checksummed sensor frame parser.
// Input channel (i_in_valid / o_in_ready): one frame byte per item, with
// i_frame_start marking byte 0. Bytes outside a frame are dropped; a start
// in mid-frame abandons the frame in progress without any result.
// Output channel (o_out_valid / i_out_ready): field results. After byte 63
// a frame with a matching 16-bit sum gives WORD_COUNT word results, then
// the air index, version and error bytes (codes 19, 20, 21), last on the
// error result; a mismatch gives a single result with checksum_ok low.
// The failure result is registered in the cycle after byte 63 is taken;
// on success the sequencer steps through its fetch and push states before
// the first result is registered. Receiving takes one byte per cycle while
// input is not held off. Emission reads each word from the word memory,
// then loads it into the output register, and loads each byte field
// directly; input is held off throughout emission.
// A stalled receiver holds the output register and the sequencer waits;
// byte 63 is also held off while an earlier result is still pending.
// Reset (synchronous, active low) returns to idle waiting for a start and
// drops any pending result; the word memory is not cleared.
`default_nettype none

module sensor_frame_checksum_parser_top #(
    parameter int unsigned WORD_COUNT = 19
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_frame_start,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [4:0]       o_field_index,
    output logic [15:0]      o_field_value,
    output logic             o_checksum_ok,
    output logic             o_last
);

    localparam int unsigned AW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

    sfcp_pkg::t_rx_status rx_status;
    logic                 acc;
    logic                 busy;
    logic                 slot_free;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [15:0]          wr_data;
    logic [AW-1:0]        rd_addr;
    logic [15:0]          rd_data;
    logic                 at_last_pos;

    // hold off byte 63 until the output register can take a failure result
    assign o_in_ready  = !busy && (slot_free || !at_last_pos);
    assign acc         = i_in_valid && o_in_ready;

    sfcp_frame_rx #(
        .WORD_COUNT (WORD_COUNT),
        .AW         (AW)
    ) u_rx (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_acc         (acc),
        .i_rx_byte     (i_rx_byte),
        .i_frame_start (i_frame_start),
        .o_at_last     (at_last_pos),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_status      (rx_status)
    );

    sfcp_word_mem #(
        .DEPTH (WORD_COUNT),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    sfcp_emit_seq #(
        .WORD_COUNT (WORD_COUNT),
        .AW         (AW)
    ) u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_status      (rx_status),
        .i_rd_data     (rd_data),
        .o_rd_addr     (rd_addr),
        .o_busy        (busy),
        .o_slot_free   (slot_free),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_field_index (o_field_index),
        .o_field_value (o_field_value),
        .o_checksum_ok (o_checksum_ok),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire

/* rtl/sfcp_checker.sv */
`default_nettype none

module sfcp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [4:0]  o_field_index,
    input wire logic [15:0] o_field_value,
    input wire logic        o_checksum_ok,
    input wire logic        o_last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_field_index) && $stable(o_field_value) &&
            $stable(o_checksum_ok) && $stable(o_last))
        else $error("result changed while stalled");

    // a failure result is a lone zero result closing the frame
    a_fail_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_checksum_ok |->
            o_last && o_field_index == 5'd0 && o_field_value == 16'd0)
        else $error("malformed failure result");

    // only the error field closes a good frame
    a_good_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_checksum_ok |->
            (o_last == (o_field_index == sfcp_pkg::CODE_ERROR)))
        else $error("last flag on wrong field");

    // input is held off while a frame's results are still being emitted
    a_no_rx_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> !o_in_ready)
        else $error("input taken during emission");

endmodule

bind sensor_frame_checksum_parser_top sfcp_checker u_sfcp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_field_index (o_field_index),
    .o_field_value (o_field_value),
    .o_checksum_ok (o_checksum_ok),
    .o_last        (o_last)
);

`default_nettype wire
